/* src/lmts_pkg.sv */
// Package for the LCD mode timing sequencer: mode codes, mode lengths,
// register indexes, state/config/result structs and the counter modulo helper.
// No dependencies.
`default_nettype none

package lmts_pkg;

   typedef enum logic [1:0] {
      MODE_HBLANK   = 2'd0,
      MODE_VBLANK   = 2'd1,
      MODE_SEARCH   = 2'd2,
      MODE_TRANSFER = 2'd3
   } mode_type;

   localparam logic [9:0] SEARCH_CYCLES   = 10'd80;
   localparam logic [9:0] TRANSFER_CYCLES = 10'd172;
   localparam logic [9:0] HBLANK_CYCLES   = 10'd204;
   localparam logic [7:0] VISIBLE_LINES   = 8'd144;

   // configuration register indexes
   localparam logic [1:0] CSR_HBLANK_IRQ_EN  = 2'd0;
   localparam logic [1:0] CSR_COMPARE_IRQ_EN = 2'd1;
   localparam logic [1:0] CSR_LINE_COMPARE   = 2'd2;

   typedef struct packed {
      logic [9:0] cycle_count;
      mode_type   mode;
      logic [7:0] line;
      logic       match_flag;
   } state_type;

   typedef struct packed {
      logic       hblank_irq_enable;
      logic       compare_irq_enable;
      logic [7:0] line_compare;
   } cfg_type;

   typedef struct packed {
      logic [1:0] display_mode;
      logic [7:0] line_number;
      logic       compare_flag;
      logic       lcd_irq_request;
      logic       vblank_irq_request;
      logic       line_done;
      logic [7:0] finished_line;
      logic       frame_done;
   } rsp_type;

   // Remainder of a 10-bit count by a fixed divisor, four restoring steps.
   // Good for any quotient below 16, which covers every mode length here.
   function automatic logic [9:0] cnt_mod(input logic [9:0] value,
                                          input logic [9:0] divisor);
      logic [12:0] rem;
      logic [12:0] shifted;
      rem = {3'b000, value};
      for (int k = 3; k >= 0; k--) begin
         shifted = {3'b000, divisor} << k;
         if (rem >= shifted) begin
            rem = rem - shifted;
         end
      end
      return rem[9:0];
   endfunction

endpackage

`default_nettype wire

/* src/lcd_mode_timing_sequencer_unit.sv */
// Top level of the LCD mode timing sequencer: handshake stages, timing state,
// configuration registers. Depends on lmts_pkg and lmts_step.
//
// Usage:
//  - Request channel (req_valid/req_ready, req_elapsed_cycles): one word per
//    batch of elapsed machine cycles. Each word yields exactly one response.
//  - Response channel (rsp_valid/rsp_ready): mode, line, compare flag and the
//    one-word interrupt / line / frame pulses after that word was applied.
//  - CSR port: csr_write_enable with csr_index 0 hblank irq enable,
//    1 compare irq enable, 2 line compare; other indexes are ignored. Write
//    only while no word is in flight.
// An accepted word passes the input register, then the response register.
// Throughput: one word per cycle, back to back, while rsp_ready is high. The
// timing state is updated combinationally (add, one-of-four modulo, line step).
// Stall: when rsp_ready is low the response register holds, and one more word
// waits in the input register; req_ready drops only when both are full.
// Reset (synchronous): mode sprite search, line 0, counter 0, flag and all
// config registers 0, both stages empty.
`default_nettype none

module lcd_mode_timing_sequencer_unit #(
   parameter int LINE_CYCLES = 456,
   parameter int TOTAL_LINES = 154
) (
   input  wire  logic       clock,
   input  wire  logic       reset,
   // request channel
   input  wire  logic       req_valid,
   output logic             req_ready,
   input  wire  logic [7:0] req_elapsed_cycles,
   // response channel
   output logic             rsp_valid,
   input  wire  logic       rsp_ready,
   output logic [1:0]       rsp_display_mode,
   output logic [7:0]       rsp_line_number,
   output logic             rsp_compare_flag,
   output logic             rsp_lcd_irq_request,
   output logic             rsp_vblank_irq_request,
   output logic             rsp_line_done,
   output logic [7:0]       rsp_finished_line,
   output logic             rsp_frame_done,
   // configuration writes
   input  wire  logic       csr_write_enable,
   input  wire  logic [1:0] csr_index,
   input  wire  logic [7:0] csr_write_data
);
   import lmts_pkg::*;

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_cycles_ff;
   // response stage
   logic       rsp_valid_ff;
   rsp_type    rsp_word_ff;
   rsp_type    rsp_word_in;
   // timing state and config
   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;

   logic advance;

   // the step fires when the input stage holds a word and the response slot frees
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   lmts_step #(
      .LINE_CYCLES(LINE_CYCLES),
      .TOTAL_LINES(TOTAL_LINES)
   ) u_step (
      .state_cur     (state_ff),
      .cfg           (cfg_ff),
      .elapsed_cycles(in_cycles_ff),
      .state_nxt     (state_in),
      .rsp           (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{cycle_count: 10'd0, mode: MODE_SEARCH,
                           line: 8'd0, match_flag: 1'b0};
         cfg_ff       <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_HBLANK_IRQ_EN:  cfg_ff.hblank_irq_enable  <= csr_write_data[0];
               CSR_COMPARE_IRQ_EN: cfg_ff.compare_irq_enable <= csr_write_data[0];
               CSR_LINE_COMPARE:   cfg_ff.line_compare       <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_cycles_ff <= req_elapsed_cycles;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_display_mode       = rsp_word_ff.display_mode;
   assign rsp_line_number        = rsp_word_ff.line_number;
   assign rsp_compare_flag       = rsp_word_ff.compare_flag;
   assign rsp_lcd_irq_request    = rsp_word_ff.lcd_irq_request;
   assign rsp_vblank_irq_request = rsp_word_ff.vblank_irq_request;
   assign rsp_line_done          = rsp_word_ff.line_done;
   assign rsp_finished_line      = rsp_word_ff.finished_line;
   assign rsp_frame_done         = rsp_word_ff.frame_done;

`ifndef NO_ASSERTIONS
   // vblank mode and the off-screen lines go together
   a_vblank_lines: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_VBLANK) == (state_ff.line >= VISIBLE_LINES))
      else $error("mode and line disagree on vblank");

   // counter remainder stays bounded
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.cycle_count} < 11'(LINE_CYCLES + 255))
      else $error("cycle counter out of range");

   // a finished visible line always lands in search or vblank
   a_line_done_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.line_done |->
         rsp_word_ff.display_mode == MODE_SEARCH ||
         rsp_word_ff.display_mode == MODE_VBLANK)
      else $error("line done into wrong mode");

   // vblank irq only on the first off-screen line
   a_vblank_irq_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.vblank_irq_request |->
         rsp_word_ff.line_number == VISIBLE_LINES && rsp_word_ff.line_done)
      else $error("vblank irq at wrong line");

   // state only moves when a word is stepped
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance && !$past(reset) |=> $stable(state_ff))
      else $error("state changed without a step");
`endif

endmodule

`default_nettype wire

/* src/lmts_step.sv */
// One timing step: adds the elapsed count and makes at most one mode change.
// Depends on lmts_pkg.
`default_nettype none

module lmts_step #(
   parameter int LINE_CYCLES = 456,
   parameter int TOTAL_LINES = 154
) (
   input  wire  lmts_pkg::state_type state_cur,
   input  wire  lmts_pkg::cfg_type   cfg,
   input  wire  logic [7:0]          elapsed_cycles,
   output lmts_pkg::state_type       state_nxt,
   output lmts_pkg::rsp_type         rsp
);
   import lmts_pkg::*;

   localparam logic [9:0] LINE_LEN = 10'(LINE_CYCLES);
   localparam logic [8:0] LINE_END = 9'(TOTAL_LINES);

   logic [10:0] sum_wide;
   logic [9:0]  sum;
   logic [8:0]  next_line;
   logic        match;

   assign sum_wide  = {1'b0, state_cur.cycle_count} + {3'b000, elapsed_cycles};
   assign sum       = sum_wide[9:0];
   assign next_line = {1'b0, state_cur.line} + 9'd1;
   assign match     = (state_cur.line == cfg.line_compare);

   always_comb begin
      state_nxt             = state_cur;
      state_nxt.cycle_count = sum;
      rsp                   = '0;
      unique case (state_cur.mode)
         MODE_SEARCH: begin
            if (sum >= SEARCH_CYCLES) begin
               state_nxt.cycle_count = cnt_mod(sum, SEARCH_CYCLES);
               state_nxt.mode        = MODE_TRANSFER;
            end
         end
         MODE_TRANSFER: begin
            if (sum >= TRANSFER_CYCLES) begin
               state_nxt.cycle_count = cnt_mod(sum, TRANSFER_CYCLES);
               state_nxt.mode        = MODE_HBLANK;
               state_nxt.match_flag  = match;
               rsp.lcd_irq_request   = cfg.hblank_irq_enable
                                       | (cfg.compare_irq_enable & match);
            end
         end
         MODE_HBLANK: begin
            if (sum >= HBLANK_CYCLES) begin
               rsp.line_done         = 1'b1;
               rsp.finished_line     = state_cur.line;
               state_nxt.line        = next_line[7:0];
               state_nxt.cycle_count = cnt_mod(sum, HBLANK_CYCLES);
               if (next_line[7:0] == VISIBLE_LINES) begin
                  state_nxt.mode         = MODE_VBLANK;
                  rsp.vblank_irq_request = 1'b1;
               end else begin
                  state_nxt.mode = MODE_SEARCH;
               end
            end
         end
         MODE_VBLANK: begin
            if (sum >= LINE_LEN) begin
               state_nxt.cycle_count = cnt_mod(sum, LINE_LEN);
               if (next_line >= LINE_END) begin
                  state_nxt.line  = 8'd0;
                  state_nxt.mode  = MODE_SEARCH;
                  rsp.frame_done  = 1'b1;
               end else begin
                  state_nxt.line = next_line[7:0];
               end
            end
         end
      endcase
      rsp.display_mode = state_nxt.mode;
      rsp.line_number  = state_nxt.line;
      rsp.compare_flag = state_nxt.match_flag;
   end

endmodule

`default_nettype wire
